// ===== src/mmh_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers for the murmur3 byte stream hasher
// no dependencies
package mmh_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2 = 32'h1b873593;
   localparam logic [31:0] ADD_N  = 32'he6546b64;
   localparam logic [31:0] FIN_M1 = 32'h85ebca6b;
   localparam logic [31:0] FIN_M2 = 32'hc2b2ae35;

   localparam int ROT_MIX  = 15;
   localparam int ROT_FOLD = 13;

   // kind of block handed from front to back
   typedef struct packed {
      logic full;
      logic last;
   } blk_ctl_type;

   localparam int CTL_BITS = $bits(blk_ctl_type);

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      rotl32 = (x << r) | (x >> (32 - r));
   endfunction

endpackage

// ===== src/mmh_fifo.sv =====
`timescale 1ns / 1ps
// small flop based queue between the front and the back of the hasher
// no package dependencies
module mmh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/mmh_front.sv =====
`timescale 1ns / 1ps
// front of the hasher: gathers bytes into little-endian blocks and counts length
// depends on mmh_pkg
module mmh_front
   import mmh_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output logic                   ent_push,
   output logic [31:0]            ent_word,
   output blk_ctl_type            ent_ctl,
   output logic [LENGTH_BITS-1:0] ent_length
);

   logic [23:0]            partial_ff, partial_in;
   logic [1:0]             pos_ff, pos_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [23:0]            merged;

   assign merged = partial_ff | ({16'b0, data_byte} << {pos_ff, 3'b000});

   always_comb begin
      partial_in    = partial_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      ent_push      = 1'b0;
      ent_word      = {8'b0, merged};
      ent_ctl.full  = 1'b0;
      ent_ctl.last  = last_byte;
      ent_length    = len_ff + 1'b1;
      if (accept) begin
         len_in = len_ff + 1'b1;
         if (pos_ff == 2'd3) begin
            ent_word     = {data_byte, partial_ff};
            ent_ctl.full = 1'b1;
            ent_push     = 1'b1;
            partial_in   = '0;
            pos_in       = '0;
         end else begin
            partial_in = merged;
            pos_in     = pos_ff + 1'b1;
            ent_push   = last_byte;
         end
         if (last_byte) begin
            partial_in = '0;
            pos_in     = '0;
            len_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pos_ff     <= '0;
         len_ff     <= '0;
      end else begin
         partial_ff <= partial_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
      end
   end

endmodule

// ===== src/mmh_back.sv =====
`timescale 1ns / 1ps
// back of the hasher: block mix, hash fold, finalizer and result register
// depends on mmh_pkg; one shared 32x32 multiplier
module mmh_back
   import mmh_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fifo_empty,
   input  logic [31:0]            fifo_word,
   input  blk_ctl_type            fifo_ctl,
   input  logic [LENGTH_BITS-1:0] fifo_length,
   output logic                   fifo_pop,
   input  logic                   rsp_pop,
   output logic                   out_valid,
   output logic [31:0]            out_hash
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROT,
      ST_FOLD,
      ST_FIN1,
      ST_FIN2,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [31:0]            prod_ff, prod_in;
   logic [31:0]            acc_ff, acc_in;
   logic [31:0]            hash_ff, hash_in;
   blk_ctl_type            ctl_ff, ctl_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   out_valid_ff, out_valid_in;
   logic [31:0]            out_hash_ff, out_hash_in;

   logic [31:0] mul_a, mul_b, mul_res;
   logic [31:0] fold_x, fold_r, fold_h;
   logic [31:0] fin_x;

   assign fold_x  = hash_ff ^ prod_ff;
   assign fold_r  = rotl32(fold_x, ROT_FOLD);
   assign fold_h  = (fold_r << 2) + fold_r + ADD_N;
   assign fin_x   = acc_ff ^ 32'(len_ff);
   assign mul_res = mul_a * mul_b;

   assign fifo_pop  = (state_ff == ST_IDLE) && !fifo_empty;
   assign out_valid = out_valid_ff;
   assign out_hash  = out_hash_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            mul_a = fifo_word;
            mul_b = MIX_C1;
         end
         ST_ROT: begin
            mul_a = rotl32(prod_ff, ROT_MIX);
            mul_b = MIX_C2;
         end
         ST_FIN1: begin
            mul_a = fin_x ^ (fin_x >> 16);
            mul_b = FIN_M1;
         end
         ST_FIN2: begin
            mul_a = prod_ff ^ (prod_ff >> 13);
            mul_b = FIN_M2;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      hash_in      = hash_ff;
      ctl_in       = ctl_ff;
      len_in       = len_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_hash_in  = out_hash_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               prod_in  = mul_res;
               ctl_in   = fifo_ctl;
               len_in   = fifo_length;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            prod_in  = mul_res;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            acc_in = ctl_ff.full ? fold_h : fold_x;
            if (ctl_ff.last) begin
               hash_in  = '0;
               state_in = ST_FIN1;
            end else begin
               hash_in  = fold_h;
               state_in = ST_IDLE;
            end
         end
         ST_FIN1: begin
            prod_in  = mul_res;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            prod_in  = mul_res;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_hash_in  = prod_ff ^ (prod_ff >> 16);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         out_valid_ff <= out_valid_in;
      end
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      ctl_ff      <= ctl_in;
      len_ff      <= len_in;
      out_hash_ff <= out_hash_in;
   end

`ifndef SYNTH
   a_seed_after_key: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD && ctl_ff.last) |=> (hash_ff == '0))
      else $error("running hash not cleared after final block");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result produced outside finalizer");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_valid_ff && !rsp_pop)
         |=> (state_ff == ST_DONE && $stable(out_hash_ff)))
      else $error("finished hash overwrote a pending result");

   a_tail_is_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> (ctl_ff.full || ctl_ff.last))
      else $error("partial block without final flag");
`endif

endmodule

// ===== src/murmur3_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
// murmur3 x86 32-bit hasher, seed zero, key streamed one byte per request
// depends on mmh_pkg, mmh_front, mmh_fifo, mmh_back
//
//   channel   handshake            payload                         direction
//   request   req_push, req_full   req_data_byte, req_last_byte    in
//   response  rsp_pop, rsp_empty   rsp_hash_value                  out
//
// every fourth byte or the final byte queues one block; the back takes a block
// through ST_IDLE, ST_ROT and ST_FOLD on the shared multiplier, so bytes of a key
// stream at one per cycle while req_full is low. a final block goes on through
// ST_FIN1, ST_FIN2 and ST_DONE. reset is synchronous and empties queue and result.
// a waiting response holds the back; the queue then fills and raises req_full.
module murmur3_byte_stream_hasher
   import mmh_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_hash_value
);

   localparam int ENT_BITS = LENGTH_BITS + 32 + CTL_BITS;

   logic                   accept;
   logic                   ent_push;
   logic [31:0]            ent_word;
   blk_ctl_type            ent_ctl;
   logic [LENGTH_BITS-1:0] ent_length;
   logic [ENT_BITS-1:0]    fifo_rdata;
   logic                   fifo_full, fifo_empty, fifo_pop;
   logic                   out_valid;

   assign req_full  = fifo_full;
   assign accept    = req_push && !fifo_full;
   assign rsp_empty = !out_valid;

   mmh_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .ent_push   (ent_push),
      .ent_word   (ent_word),
      .ent_ctl    (ent_ctl),
      .ent_length (ent_length)
   );

   mmh_fifo #(
      .WIDTH(ENT_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (ent_push),
      .wdata ({ent_length, ent_word, ent_ctl}),
      .pop   (fifo_pop),
      .rdata (fifo_rdata),
      .full  (fifo_full),
      .empty (fifo_empty)
   );

   mmh_back #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_empty  (fifo_empty),
      .fifo_word   (fifo_rdata[CTL_BITS +: 32]),
      .fifo_ctl    (blk_ctl_type'(fifo_rdata[CTL_BITS-1:0])),
      .fifo_length (fifo_rdata[ENT_BITS-1 -: LENGTH_BITS]),
      .fifo_pop    (fifo_pop),
      .rsp_pop     (rsp_pop),
      .out_valid   (out_valid),
      .out_hash    (rsp_hash_value)
   );

endmodule
